[design/two_channel_waveform_generator_core_assert.svh]
// assertion helpers shared by the generator modules
// every user has clk and rst_n in scope
`ifndef TWO_CHANNEL_WAVEFORM_GENERATOR_CORE_ASSERT_SVH
`define TWO_CHANNEL_WAVEFORM_GENERATOR_CORE_ASSERT_SVH

// condition implies consequence in the same cycle
`define TCWG_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcwg check failed");

// condition implies consequence in the next cycle
`define TCWG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcwg check failed");

// condition must never be seen
`define TCWG_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tcwg check failed");

`endif

[design/tcwg_pkg.sv]
package tcwg_pkg;

  typedef enum logic [1:0] {
    WAVE_SQUARE   = 2'd0,
    WAVE_TRIANGLE = 2'd1,
    WAVE_SINE     = 2'd2,
    WAVE_OFF      = 2'd3
  } wave_t;

  // register indexes of the write port
  localparam logic [2:0] REG_STEP_L   = 3'd0;
  localparam logic [2:0] REG_STEP_R   = 3'd1;
  localparam logic [2:0] REG_OFFSET_L = 3'd2;
  localparam logic [2:0] REG_OFFSET_R = 3'd3;
  localparam logic [2:0] REG_AMP_L    = 3'd4;
  localparam logic [2:0] REG_AMP_R    = 3'd5;
  localparam logic [2:0] REG_WAVE_L   = 3'd6;
  localparam logic [2:0] REG_WAVE_R   = 3'd7;

  localparam logic [30:0] STEP_RESET = 31'd2118123;
  localparam logic [6:0]  AMP_RESET  = 7'd80;
  localparam logic [7:0]  MID        = 8'h7f;

  // quarter-wave table entries are fractions of full scale
  localparam int          SINE_W    = 15;
  localparam logic [14:0] SINE_FULL = 15'd32767;
  localparam logic [22:0] SINE_BASE = 23'd4161409;  // mid times full scale

  // q30 coefficients of the odd sine polynomial
  localparam logic [30:0] SIN_C1 = 31'd1686629713;
  localparam logic [30:0] SIN_C3 = 31'd693598668;
  localparam logic [30:0] SIN_C5 = 31'd85569306;
  localparam logic [30:0] SIN_C7 = 31'd5026995;
  localparam logic [30:0] SIN_C9 = 31'd172272;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic [1:0][30:0] step;
    logic [1:0][31:0] offset;
    logic [1:0][6:0]  amp;
    wave_t [1:0]      wave;
  } cfg_t;

  typedef enum logic [3:0] {
    FS_SQR,
    FS_C9,
    FS_C7,
    FS_C5,
    FS_C3,
    FS_C1,
    FS_SCALE,
    FS_WRITE,
    FS_DONE
  } fill_state_t;

endpackage

[design/tcwg_queue.sv]
module tcwg_queue
  import tcwg_pkg::*;
#(
  parameter int W = 33
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output logic         empty,
  output logic         full
);

  logic [W-1:0]      entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign pop_data = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

`include "two_channel_waveform_generator_core_assert.svh"

  `TCWG_ASSERT_NEVER(a_q_overflow, push && full && !pop)
  `TCWG_ASSERT_NEVER(a_q_underflow, pop && empty)

endmodule

[design/tcwg_front.sv]
module tcwg_front
  import tcwg_pkg::*;
#(
  parameter int PHASE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              rom_ready,
  input  logic              in_valid,
  input  logic              in_channel,
  output logic              in_stall,
  input  logic              q_full,
  output logic              push,
  output logic [PHASE_BITS:0] push_data
);

  localparam int WIDE  = (PHASE_BITS > 32) ? PHASE_BITS : 32;
  localparam int SH_UP = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int SH_DN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

  logic [PHASE_BITS-1:0] acc_r [2];
  logic [PHASE_BITS-1:0] acc_nxt;
  logic [WIDE-1:0]       step_w;
  logic [PHASE_BITS-1:0] step_al;

  // step registers are in 2^-32 units, move them to accumulator units
  assign step_w  = WIDE'({1'b0, cfg.step[in_channel]});
  assign step_al = PHASE_BITS'((step_w << SH_UP) >> SH_DN);
  assign acc_nxt = acc_r[in_channel] + step_al;

  assign in_stall  = q_full || !rom_ready;
  assign push      = in_valid && !in_stall;
  assign push_data = {in_channel, acc_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r[0] <= '0;
      acc_r[1] <= '0;
    end else if (push) begin
      acc_r[in_channel] <= acc_nxt;
    end
  end

endmodule

[design/tcwg_sine_rom.sv]
module tcwg_sine_rom
  import tcwg_pkg::*;
#(
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  output logic                      ready,
  input  logic                      rd_en,
  input  logic [SINE_ADDR_BITS-2:0] rd_addr,
  output logic [SINE_W-1:0]         rd_data
);

  localparam int AW    = SINE_ADDR_BITS - 1;
  localparam int Q     = 1 << (SINE_ADDR_BITS - 2);
  localparam int DEPTH = Q + 1;
  localparam int XSH   = 32 - SINE_ADDR_BITS;

  logic [SINE_W-1:0] mem [DEPTH];
  logic [SINE_W-1:0] rd_data_r;

  fill_state_t state_r, state_nxt;
  logic [AW-1:0] j_r, j_nxt;
  logic [30:0]   x2_r, x2_nxt;
  logic [61:0]   prod_r, prod_nxt;
  logic [30:0]   x_val, prod_hi, mul_a, mul_b;
  logic [46:0]   rnd;
  logic [16:0]   e_full;
  logic [SINE_W-1:0] e_val;
  logic          wr_en;

  // x = j / Q in q30
  assign x_val   = 31'(j_r) << XSH;
  assign prod_hi = prod_r[60:30];
  assign prod_nxt = 62'(mul_a) * 62'(mul_b);

  assign rnd    = prod_r[46:0] + 47'd536870912;
  assign e_full = rnd[46:30];
  assign e_val  = (e_full > 17'(SINE_FULL)) ? SINE_FULL : e_full[SINE_W-1:0];

  // one shared multiplier walks the horner chain for each table entry in turn
  always_comb begin
    state_nxt = state_r;
    j_nxt     = j_r;
    x2_nxt    = x2_r;
    mul_a     = x_val;
    mul_b     = x_val;
    wr_en     = 1'b0;
    case (state_r)
      FS_SQR: begin
        state_nxt = FS_C9;
      end
      FS_C9: begin
        mul_a     = prod_hi;
        mul_b     = SIN_C9;
        x2_nxt    = prod_hi;
        state_nxt = FS_C7;
      end
      FS_C7: begin
        mul_a     = x2_r;
        mul_b     = SIN_C7 - prod_hi;
        state_nxt = FS_C5;
      end
      FS_C5: begin
        mul_a     = x2_r;
        mul_b     = SIN_C5 - prod_hi;
        state_nxt = FS_C3;
      end
      FS_C3: begin
        mul_a     = x2_r;
        mul_b     = SIN_C3 - prod_hi;
        state_nxt = FS_C1;
      end
      FS_C1: begin
        mul_a     = x_val;
        mul_b     = SIN_C1 - prod_hi;
        state_nxt = FS_SCALE;
      end
      FS_SCALE: begin
        mul_a     = prod_hi;
        mul_b     = 31'(SINE_FULL);
        state_nxt = FS_WRITE;
      end
      FS_WRITE: begin
        wr_en = 1'b1;
        if (j_r == AW'(Q)) begin
          state_nxt = FS_DONE;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = FS_SQR;
        end
      end
      FS_DONE: begin
        state_nxt = FS_DONE;
      end
      default: begin
        state_nxt = FS_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_SQR;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      j_r     <= j_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x2_r   <= x2_nxt;
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[j_r] <= e_val;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign ready   = (state_r == FS_DONE);
  assign rd_data = rd_data_r;

`include "two_channel_waveform_generator_core_assert.svh"

  `TCWG_ASSERT_NEXT(a_fill_once, state_r == FS_DONE, state_r == FS_DONE)
  `TCWG_ASSERT_IMPLY(a_fill_addr, state_r == FS_WRITE, j_r <= AW'(Q))

endmodule

[design/tcwg_back.sv]
module tcwg_back
  import tcwg_pkg::*;
#(
  parameter int PHASE_BITS     = 32,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_t                      cfg,
  input  logic                      q_empty,
  input  logic [PHASE_BITS:0]       q_data,
  output logic                      q_pop,
  output logic                      rd_en,
  output logic [SINE_ADDR_BITS-2:0] rd_addr,
  input  logic [SINE_W-1:0]         rd_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [7:0]                out_sample,
  output logic                      out_sample_channel
);

  localparam int PW    = PHASE_BITS;
  localparam int S     = SINE_ADDR_BITS;
  localparam int AW    = SINE_ADDR_BITS - 1;
  localparam int Q     = 1 << (SINE_ADDR_BITS - 2);
  localparam int TW    = PHASE_BITS + 7;
  localparam int WIDE  = (PHASE_BITS > 32) ? PHASE_BITS : 32;
  localparam int SH_UP = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
  localparam int SH_DN = (PHASE_BITS < 32) ? 32 - PHASE_BITS : 0;

  logic adv;

  // stage 1: phase with offset
  logic          q_ch;
  logic [PW-1:0] q_acc;
  logic [WIDE-1:0] off_w;
  logic [PW-1:0] ph_nxt;
  logic          v1_r, ch1_r;
  wave_t         wave1_r;
  logic [6:0]    amp1_r;
  logic [PW-1:0] ph1_r;

  // stage 2: triangle distance and table address
  logic [1:0]    s_top;
  logic [PW-1:0] s_val, d_nxt;
  logic [S-1:0]  adr;
  logic [S-3:0]  k;
  logic          v2_r, ch2_r, top2_r, neg2_r;
  wave_t         wave2_r;
  logic [6:0]    amp2_r;
  logic [PW-1:0] d2_r;

  // stage 3: products
  logic          v3_r, ch3_r, top3_r, neg3_r;
  wave_t         wave3_r;
  logic [6:0]    amp3_r;
  logic [TW-1:0] tri3_r;
  logic [21:0]   sin3_r;

  // output register
  logic          out_valid_r, out_ch_r;
  logic [7:0]    out_sample_r, sample_nxt;
  logic [7:0]    term, tri_smp, sq_smp, q0, sin_smp;
  logic [22:0]   num;
  logic [15:0]   rem;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;
  assign rd_en = adv;

  assign q_ch   = q_data[PW];
  assign q_acc  = q_data[PW-1:0];
  assign off_w  = WIDE'(cfg.offset[q_ch]);
  assign ph_nxt = q_acc + PW'((off_w << SH_UP) >> SH_DN);

  // a quarter period only touches the top two phase bits
  assign s_top = ph1_r[PW-1:PW-2] + 2'd1;
  assign s_val = {s_top, ph1_r[PW-3:0]};
  assign d_nxt = s_val[PW-1] ? (~s_val + PW'(1)) : s_val;

  // quadrants 1 and 3 read the table mirrored
  assign adr     = ph1_r[PW-1:PW-S];
  assign k       = adr[S-3:0];
  assign rd_addr = adr[S-2] ? (AW'(Q) - AW'(k)) : AW'(k);

  assign term    = tri3_r[PW+5:PW-2];
  assign tri_smp = MID - {1'b0, amp3_r} + term;
  assign sq_smp  = top3_r ? MID - {1'b0, amp3_r} : MID + {1'b0, amp3_r};

  // divide by 2^15-1: high part plus one correction step
  assign num     = neg3_r ? SINE_BASE - 23'(sin3_r) : SINE_BASE + 23'(sin3_r);
  assign q0      = num[22:15];
  assign rem     = 16'(num[14:0]) + 16'(q0);
  assign sin_smp = (rem >= 16'(SINE_FULL)) ? q0 + 8'd1 : q0;

  always_comb begin
    case (wave3_r)
      WAVE_SQUARE:   sample_nxt = sq_smp;
      WAVE_TRIANGLE: sample_nxt = tri_smp;
      WAVE_SINE:     sample_nxt = sin_smp;
      WAVE_OFF:      sample_nxt = 8'd0;
      default:       sample_nxt = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= q_pop;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ch1_r   <= q_ch;
      wave1_r <= cfg.wave[q_ch];
      amp1_r  <= cfg.amp[q_ch];
      ph1_r   <= ph_nxt;

      ch2_r   <= ch1_r;
      wave2_r <= wave1_r;
      amp2_r  <= amp1_r;
      d2_r    <= d_nxt;
      top2_r  <= ph1_r[PW-1];
      neg2_r  <= adr[S-1];

      ch3_r   <= ch2_r;
      wave3_r <= wave2_r;
      amp3_r  <= amp2_r;
      top3_r  <= top2_r;
      neg3_r  <= neg2_r;
      tri3_r  <= TW'(amp2_r) * TW'(d2_r);
      sin3_r  <= 22'(amp2_r) * 22'(rd_data);

      out_ch_r     <= ch3_r;
      out_sample_r <= sample_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sample         = out_sample_r;
  assign out_sample_channel = out_ch_r;

endmodule

[design/two_channel_waveform_generator_core.sv]
// Two-channel DDS waveform generator.
// Input channel (in_valid / in_stall / in_channel): each word is one sample
// tick for channel 0 (left) or 1 (right); it advances that channel's phase
// accumulator and yields exactly one output word.
// Output channel (out_valid / out_stall / out_sample / out_sample_channel):
// unsigned 8-bit sample centred on 127, tagged with its channel, in order.
// Config port (cfg_we / cfg_index / cfg_data): per-channel phase step,
// phase offset, amplitude and waveform; write only while the block is idle.
// Throughput is one word per cycle while out_stall is low; a taken input
// passes the queue, offset add, table read, multiply and output register.
// After reset the quarter-wave sine table, 2^(SINE_ADDR_BITS-2)+1 entries
// (257 at the default size), is computed by one shared multiplier;
// in_stall stays high until the table is done.
// Reset clears both accumulators and loads the default configuration.
// While out_valid and out_stall are high the output word and back pipeline
// freeze, and a 4-word queue absorbs input, raising in_stall when full.
module two_channel_waveform_generator_core
  import tcwg_pkg::*;
#(
  parameter int PHASE_BITS     = 32,
  parameter int SINE_ADDR_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_channel,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_sample,
  output logic        out_sample_channel,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;

  logic                      rom_ready;
  logic                      q_full, q_empty, q_push, q_pop;
  logic [PHASE_BITS:0]       q_wdata, q_rdata;
  logic                      rd_en;
  logic [SINE_ADDR_BITS-2:0] rd_addr;
  logic [SINE_W-1:0]         rd_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_STEP_L:   cfg_nxt.step[0]   = cfg_data[30:0];
        REG_STEP_R:   cfg_nxt.step[1]   = cfg_data[30:0];
        REG_OFFSET_L: cfg_nxt.offset[0] = cfg_data;
        REG_OFFSET_R: cfg_nxt.offset[1] = cfg_data;
        REG_AMP_L:    cfg_nxt.amp[0]    = cfg_data[6:0];
        REG_AMP_R:    cfg_nxt.amp[1]    = cfg_data[6:0];
        REG_WAVE_L:   cfg_nxt.wave[0]   = wave_t'(cfg_data[1:0]);
        REG_WAVE_R:   cfg_nxt.wave[1]   = wave_t'(cfg_data[1:0]);
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step[0]   <= STEP_RESET;
      cfg_r.step[1]   <= STEP_RESET;
      cfg_r.offset[0] <= '0;
      cfg_r.offset[1] <= '0;
      cfg_r.amp[0]    <= AMP_RESET;
      cfg_r.amp[1]    <= AMP_RESET;
      cfg_r.wave[0]   <= WAVE_SINE;
      cfg_r.wave[1]   <= WAVE_SINE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcwg_front #(
    .PHASE_BITS(PHASE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .rom_ready (rom_ready),
    .in_valid  (in_valid),
    .in_channel(in_channel),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_wdata)
  );

  tcwg_queue #(
    .W(PHASE_BITS + 1)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_data(q_wdata),
    .pop      (q_pop),
    .pop_data (q_rdata),
    .empty    (q_empty),
    .full     (q_full)
  );

  tcwg_sine_rom #(
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) u_rom (
    .clk    (clk),
    .rst_n  (rst_n),
    .ready  (rom_ready),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  tcwg_back #(
    .PHASE_BITS    (PHASE_BITS),
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_data            (q_rdata),
    .q_pop             (q_pop),
    .rd_en             (rd_en),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample        (out_sample),
    .out_sample_channel(out_sample_channel)
  );

`include "two_channel_waveform_generator_core_assert.svh"

  `TCWG_ASSERT_IMPLY(a_no_take_in_fill, !rom_ready, in_stall)

endmodule
